### hw/rtl/o3k_pkg.sv
// o3k_pkg: types, constants and microcode store for the three-wheel omni kinematics.
// Used by o3k_datapath and omni3_accel_limited_kinematics; no dependencies.
`default_nettype none
package o3k_pkg;

  typedef enum logic [1:0] {
    CFG_ACCEL_STEP = 2'd0,
    CFG_RADIUS     = 2'd1,
    CFG_RPM_GAIN   = 2'd2,
    CFG_RESERVED   = 2'd3
  } cfg_idx_e;

  localparam logic [11:0] ACCEL_STEP_RST = 12'd50;
  localparam logic [9:0]  RADIUS_RST     = 10'd200;
  localparam logic [15:0] RPM_GAIN_RST   = 16'd611;

  localparam logic signed [17:0] SIN60_Q15 = 18'sd28378;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_YAW  = 3'd1,
    MUL_S60  = 3'd2,
    MUL_LO   = 3'd3,
    MUL_HI   = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [2:0] {
    JMP_NEXT    = 3'd0,
    JMP_WAIT_IN = 3'd1,
    JMP_LOOP    = 3'd2,
    JMP_OUT     = 3'd3,
    JMP_ALWAYS  = 3'd4
  } jmp_e;

  localparam int unsigned UpcW = 4;
  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UPC_WAIT  = 4'd0;
  localparam upc_t UPC_WHEEL = 4'd4;
  localparam upc_t UPC_OUT   = 4'd8;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     ld_yaw;
    logic     ld_s60;
    logic     ld_mixa;
    acc_op_e  acc_op;
    logic     wr_wheel;
    jmp_e     jmp;
    upc_t     target;
  } ucode_t;

  typedef struct packed {
    logic   accept;
    ucode_t uc;
  } dp_ctrl_t;

  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t w;
    w = '{mul_sel: MUL_NONE, ld_yaw: 1'b0, ld_s60: 1'b0, ld_mixa: 1'b0,
          acc_op: ACC_HOLD, wr_wheel: 1'b0, jmp: JMP_NEXT, target: UPC_WAIT};
    case (upc)
      4'd0: w.jmp = JMP_WAIT_IN;
      4'd1: w.mul_sel = MUL_YAW;
      4'd2: begin
        w.ld_yaw  = 1'b1;
        w.mul_sel = MUL_S60;
      end
      4'd3: begin
        w.ld_s60  = 1'b1;
        w.ld_mixa = 1'b1;
      end
      4'd4: w.mul_sel = MUL_LO;
      4'd5: begin
        w.acc_op  = ACC_LOAD;
        w.mul_sel = MUL_HI;
      end
      4'd6: w.acc_op = ACC_ADD;
      4'd7: begin
        w.wr_wheel = 1'b1;
        w.jmp      = JMP_LOOP;
        w.target   = UPC_WHEEL;
      end
      4'd8: begin
        w.jmp    = JMP_OUT;
        w.target = UPC_WAIT;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = UPC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/o3k_cmd_if.sv
// o3k_cmd_if: valid/ready channel carrying one chassis velocity request.
// No dependencies.
`default_nettype none
interface o3k_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_vx;
  logic signed [15:0] target_vy;
  logic signed [15:0] target_wz;

  modport source(output valid, output target_vx, output target_vy, output target_wz,
                 input ready);
  modport sink(input valid, input target_vx, input target_vy, input target_wz,
               output ready);
endinterface
`default_nettype wire

### hw/rtl/o3k_wheel_if.sv
// o3k_wheel_if: valid/ready channel carrying one request of three wheel speeds.
// No dependencies.
`default_nettype none
interface o3k_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_a_rpm;
  logic signed [15:0] wheel_b_rpm;
  logic signed [15:0] wheel_c_rpm;

  modport source(output valid, output wheel_a_rpm, output wheel_b_rpm, output wheel_c_rpm,
                 input ready);
  modport sink(input valid, input wheel_a_rpm, input wheel_b_rpm, input wheel_c_rpm,
               output ready);
endinterface
`default_nettype wire

### hw/rtl/omni3_accel_limited_kinematics.sv
// Three-wheel omni chassis inverse kinematics with per-request acceleration limit.
// Depends on o3k_pkg, o3k_cmd_if, o3k_wheel_if and o3k_datapath.
//
// One velocity request in, one request of three wheel speeds out. A new request
// is taken only after the previous result has moved into the output register,
// and the block waits for that while the output side stalls. Every product is
// formed by a single shared 18x18 multiplier under microcode control: two
// products for the yaw and sine terms, then two partial products per wheel for
// the rpm gain. The output register holds a finished result while the next
// request is being worked on.
// Configuration registers may be written whenever no request is in flight.
`default_nettype none
module omni3_accel_limited_kinematics (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  o3k_cmd_if.sink    cmd,
  o3k_wheel_if.source wheel
);

  logic [11:0]        accel_step_q;
  logic [9:0]         radius_q;
  logic [15:0]        rpm_gain_q;
  o3k_pkg::upc_t      upc_q, upc_d;
  o3k_pkg::ucode_t    uc;
  o3k_pkg::dp_ctrl_t  dp_ctrl;
  logic               accept, out_fire, wheel_last, out_valid_q;
  logic signed [15:0] wa, wb, wc, out_a_q, out_b_q, out_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_step_q <= o3k_pkg::ACCEL_STEP_RST;
      radius_q     <= o3k_pkg::RADIUS_RST;
      rpm_gain_q   <= o3k_pkg::RPM_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (o3k_pkg::cfg_idx_e'(cfg_idx_i))
        o3k_pkg::CFG_ACCEL_STEP: accel_step_q <= cfg_data_i[11:0];
        o3k_pkg::CFG_RADIUS:     radius_q     <= cfg_data_i[9:0];
        o3k_pkg::CFG_RPM_GAIN:   rpm_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign uc        = o3k_pkg::ucode_rom(upc_q);
  assign cmd.ready = (upc_q == o3k_pkg::UPC_WAIT);
  assign accept    = cmd.valid && cmd.ready;
  assign out_fire  = (upc_q == o3k_pkg::UPC_OUT) && (!out_valid_q || wheel.ready);

  always_comb begin
    upc_d = upc_q + o3k_pkg::upc_t'(1);
    unique case (uc.jmp)
      o3k_pkg::JMP_WAIT_IN: if (!accept) upc_d = upc_q;
      o3k_pkg::JMP_LOOP:    if (!wheel_last) upc_d = uc.target;
      o3k_pkg::JMP_OUT:     upc_d = out_fire ? uc.target : upc_q;
      o3k_pkg::JMP_ALWAYS:  upc_d = uc.target;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= o3k_pkg::UPC_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (wheel.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_a_q <= wa;
      out_b_q <= wb;
      out_c_q <= wc;
    end
  end

  assign dp_ctrl.accept = accept;
  assign dp_ctrl.uc     = uc;

  o3k_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dp_ctrl),
    .target_vx_i  (cmd.target_vx),
    .target_vy_i  (cmd.target_vy),
    .target_wz_i  (cmd.target_wz),
    .accel_step_i (accel_step_q),
    .radius_i     (radius_q),
    .rpm_gain_i   (rpm_gain_q),
    .wheel_last_o (wheel_last),
    .wheel_a_o    (wa),
    .wheel_b_o    (wb),
    .wheel_c_o    (wc)
  );

  assign wheel.valid       = out_valid_q;
  assign wheel.wheel_a_rpm = out_a_q;
  assign wheel.wheel_b_rpm = out_b_q;
  assign wheel.wheel_c_rpm = out_c_q;

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= o3k_pkg::UPC_OUT) else $error("step counter out of program");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q) == o3k_pkg::UPC_OUT)
    else $error("result raised outside output step");
  a_accept_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> upc_q == o3k_pkg::upc_t'(1)) else $error("request did not start program");

endmodule
`default_nettype wire

### hw/rtl/o3k_datapath.sv
// o3k_datapath: held velocities, shared 18x18 multiplier, mix, accumulator and rounding.
// Driven by the microcode word from the top level; depends on o3k_pkg.
`default_nettype none
module o3k_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire o3k_pkg::dp_ctrl_t  ctrl_i,
  input  wire logic signed [15:0] target_vx_i,
  input  wire logic signed [15:0] target_vy_i,
  input  wire logic signed [15:0] target_wz_i,
  input  wire logic [11:0]        accel_step_i,
  input  wire logic [9:0]         radius_i,
  input  wire logic [15:0]        rpm_gain_i,
  output logic                    wheel_last_o,
  output logic signed [15:0]      wheel_a_o,
  output logic signed [15:0]      wheel_b_o,
  output logic signed [15:0]      wheel_c_o
);

  logic signed [15:0] hvx_q, hvy_q, twz_q;
  logic signed [35:0] prod_q, prod_d;
  logic signed [29:0] yaw_q;
  logic signed [31:0] s60_q;
  logic signed [33:0] mix_q, mix_a, mix_b, mix_c, yaw_x, half_x, s60_x;
  logic signed [51:0] acc_q, rnd;
  logic signed [28:0] rq;
  logic signed [15:0] sat;
  logic signed [17:0] ma, mb;
  logic [1:0]         wsel_q;
  logic signed [15:0] wheel_q [3];

  function automatic logic signed [15:0] limit_axis(input logic signed [15:0] t,
                                                    input logic signed [15:0] h,
                                                    input logic [11:0] s);
    logic signed [17:0] up, dn, t18;
    logic signed [15:0] r;
    up  = 18'(h) + $signed({6'b0, s});
    dn  = 18'(h) - $signed({6'b0, s});
    t18 = 18'(t);
    if (t == 16'sd0) begin
      r = 16'sd0;
    end else if (t > h) begin
      r = (up > t18) ? t : up[15:0];
    end else if (t < h) begin
      r = (dn < t18) ? t : dn[15:0];
    end else begin
      r = t;
    end
    return r;
  endfunction

  always_comb begin
    case (ctrl_i.uc.mul_sel)
      o3k_pkg::MUL_YAW: begin
        ma = 18'(twz_q);
        mb = $signed({8'b0, radius_i});
      end
      o3k_pkg::MUL_S60: begin
        ma = 18'(hvy_q);
        mb = o3k_pkg::SIN60_Q15;
      end
      o3k_pkg::MUL_LO: begin
        ma = $signed({1'b0, mix_q[16:0]});
        mb = $signed({2'b0, rpm_gain_i});
      end
      o3k_pkg::MUL_HI: begin
        ma = $signed({mix_q[33], mix_q[33:17]});
        mb = $signed({2'b0, rpm_gain_i});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_d = ma * mb;
  end

  assign yaw_x  = 34'(yaw_q);
  assign half_x = $signed({{4{hvx_q[15]}}, hvx_q, 14'b0});
  assign s60_x  = 34'(s60_q);
  assign mix_a  = $signed({{3{hvx_q[15]}}, hvx_q, 15'b0}) + yaw_x;
  assign mix_b  = yaw_x - s60_x - half_x;
  assign mix_c  = yaw_x + s60_x - half_x;

  assign rnd = acc_q + 52'sd4194304;
  assign rq  = rnd[51:23];
  always_comb begin
    if (rq > 29'sd32767) begin
      sat = 16'sh7FFF;
    end else if (rq < -29'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = rq[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvx_q  <= '0;
      hvy_q  <= '0;
      wsel_q <= '0;
    end else begin
      if (ctrl_i.accept) begin
        hvx_q <= limit_axis(target_vx_i, hvx_q, accel_step_i);
        hvy_q <= limit_axis(target_vy_i, hvy_q, accel_step_i);
      end
      if (ctrl_i.uc.ld_mixa) begin
        wsel_q <= '0;
      end else if (ctrl_i.uc.wr_wheel) begin
        wsel_q <= wheel_last_o ? 2'd0 : wsel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) twz_q <= target_wz_i;
    if (ctrl_i.uc.mul_sel != o3k_pkg::MUL_NONE) prod_q <= prod_d;
    if (ctrl_i.uc.ld_yaw) yaw_q <= {prod_q[26:0], 3'b0};
    if (ctrl_i.uc.ld_s60) s60_q <= prod_q[31:0];
    if (ctrl_i.uc.ld_mixa) begin
      mix_q <= mix_a;
    end else if (ctrl_i.uc.wr_wheel) begin
      mix_q <= (wsel_q == 2'd0) ? mix_b : mix_c;
    end
    case (ctrl_i.uc.acc_op)
      o3k_pkg::ACC_LOAD: acc_q <= 52'(prod_q);
      o3k_pkg::ACC_ADD:  acc_q <= acc_q + $signed({prod_q[34:0], 17'b0});
      default:           acc_q <= acc_q;
    endcase
    if (ctrl_i.uc.wr_wheel) wheel_q[wsel_q] <= sat;
  end

  assign wheel_last_o = (wsel_q == 2'd2);
  assign wheel_a_o    = wheel_q[0];
  assign wheel_b_o    = wheel_q[1];
  assign wheel_c_o    = wheel_q[2];

  a_wsel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wsel_q != 2'd3) else $error("wheel index out of range");
  a_zero_stop_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.accept && target_vx_i == 16'sd0 |=> hvx_q == 16'sd0)
    else $error("zero vx target did not stop axis");
  a_zero_stop_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.accept && target_vy_i == 16'sd0 |=> hvy_q == 16'sd0)
    else $error("zero vy target did not stop axis");

endmodule
`default_nettype wire
